// File: hw/rtl/fed_pkg.sv
// Package with the shared constants, types and register codes of the echo delay block.
package fed_pkg;

  // Sample and register field widths.
  localparam int SAMPLE_W = 16;
  localparam int PCT_W    = 7;
  localparam int DLY_W    = 17;

  // Echo ring geometry.
  localparam int RING_DEPTH = 65536;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int DCMP_W     = (CNT_W > DLY_W) ? CNT_W : DLY_W;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Percent limits and reset values of the registers.
  localparam int WET_MAX  = 100;
  localparam int FB_MAX   = 99;
  localparam int PCT_FULL = 100;
  localparam int RST_WET  = 50;
  localparam int RST_FB   = 50;
  localparam int RST_DLY  = 22050;

  // Saturation bounds of a 16-bit sample.
  localparam int SAT_MAX     = 32767;
  localparam int SAT_MIN     = -32768;
  localparam int SAT_MAG_MIN = 32768;

  // Datapath widths: products, sums, magnitudes and quotients.
  localparam int PROD_W = 24;
  localparam int SUM_W  = 25;
  localparam int MAG_W  = 23;
  localparam int QUO_W  = 17;

  // Division by 100 as a multiplication by ceil(2^30 / 100) and a shift.
  localparam int RECIP_W   = 24;
  localparam int RECIP     = 10737419;
  localparam int DIV_SHIFT = 30;
  localparam int MULQ_W    = MAG_W + RECIP_W;

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_WET = 2'd0,
    REG_FB  = 2'd1,
    REG_DLY = 2'd2
  } fed_reg_t;

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] dry;
    logic [ADDR_W-1:0]          wp;
    logic [ADDR_W-1:0]          rp;
    logic                       fx_zero;
  } fed_item_t;

  // Mix settings used by the back.
  typedef struct packed {
    logic [PCT_W-1:0] wet;
    logic [PCT_W-1:0] fb;
  } fed_cfg_t;

endpackage

// File: hw/rtl/fed_if.sv
// Valid/ready channel interfaces for input samples and mixed results.
interface fed_in_if import fed_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       silent;
  logic                       flush_first;

  modport source (output valid, sample_in, silent, flush_first, input ready);
  modport sink (input valid, sample_in, silent, flush_first, output ready);
endinterface

interface fed_out_if import fed_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       nonzero_out;

  modport source (output valid, sample_out, nonzero_out, input ready);
  modport sink (input valid, sample_out, nonzero_out, output ready);
endinterface

// File: hw/rtl/fed_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module fed_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 65536,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while the read is not enabled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/fed_queue.sv
// Short FIFO of classified requests between the front and the back.
module fed_queue import fed_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  fed_item_t push_item,
  output logic      push_ready,
  output logic      pop_valid,
  output fed_item_t pop_item,
  input  logic      pop_ready
);

  fed_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  // Handshakes on both sides.
  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: hw/rtl/fed_front.sv
// Front end: accepts samples, tracks the write position and ring fill, classifies each request.
module fed_front import fed_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  fed_in_if.sink           in_ch,
  input  logic [DLY_W-1:0] dly,
  output logic             push_valid,
  output fed_item_t        push_item,
  input  logic             push_ready
);

  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  fill_eff;
  logic [DCMP_W-1:0] dly_ext, dly_eff, wp_ext, rp_ext;
  logic              push;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign push        = in_ch.valid && push_ready;

  // Clamp the delay to one through the ring depth.
  always_comb begin
    dly_ext = DCMP_W'(dly);
    if (dly_ext == '0) begin
      dly_eff = DCMP_W'(1);
    end else if (dly_ext > DCMP_W'(RING_DEPTH)) begin
      dly_eff = DCMP_W'(RING_DEPTH);
    end else begin
      dly_eff = dly_ext;
    end
  end

  // The fill count holds how many entries behind the write position were written
  // since reset or the last flush; anything older reads as zero.
  always_comb begin
    fill_eff = in_ch.flush_first ? '0 : fill_r;
    wp_ext   = DCMP_W'(wp_r);
    if (wp_ext >= dly_eff) begin
      rp_ext = wp_ext - dly_eff;
    end else begin
      rp_ext = wp_ext + DCMP_W'(RING_DEPTH) - dly_eff;
    end
    push_item.dry     = in_ch.silent ? '0 : in_ch.sample_in;
    push_item.wp      = wp_r;
    push_item.rp      = rp_ext[ADDR_W-1:0];
    push_item.fx_zero = (dly_eff > DCMP_W'(fill_eff));
  end

  // Advance the write position and the fill count on every accepted request.
  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (push) begin
      wp_nxt   = (wp_r == ADDR_W'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      fill_nxt = (fill_eff == CNT_W'(RING_DEPTH)) ? fill_eff : fill_eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

`ifndef SYNTHESIS
  // After a flush only the entry written by the flushing request counts as filled.
  a_flush_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_ch.flush_first) |=> (fill_r == CNT_W'(1)))
    else $error("fill count wrong after flush");

  // The write position stays inside the ring.
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> (wp_r <= ADDR_W'(RING_DEPTH - 1)))
    else $error("write position outside the ring");
`endif

endmodule

// File: hw/rtl/fed_back.sv
// Back end: ring read with hazard stall, mix arithmetic pipeline, ring write-back and result register.
module fed_back import fed_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  input  fed_item_t pop_item,
  output logic      pop_ready,
  input  fed_cfg_t  cfg,
  fed_out_if.source out_ch
);

  logic advance, hazard, pop;

  // Stage 0: ring read in flight.
  logic                       s0_v_r;
  logic [ADDR_W-1:0]          s0_wp_r;
  logic signed [SAMPLE_W-1:0] s0_dry_r;
  logic                       s0_zero_r;
  logic [SAMPLE_W-1:0]        ram_rdata;

  // Stage 1: products.
  logic                     s1_v_r;
  logic [ADDR_W-1:0]        s1_wp_r;
  logic signed [PROD_W-1:0] s1_fb_r, s1_fb_nxt;
  logic signed [PROD_W-1:0] s1_d100_r, s1_d100_nxt;
  logic signed [PROD_W-1:0] s1_wet_r, s1_wet_nxt;
  logic signed [PROD_W-1:0] s1_dmix_r, s1_dmix_nxt;

  // Stage 2: sign and magnitude of the sums.
  logic              s2_v_r;
  logic [ADDR_W-1:0] s2_wp_r;
  logic              s2_rneg_r, s2_rneg_nxt, s2_oneg_r, s2_oneg_nxt;
  logic [MAG_W-1:0]  s2_rmag_r, s2_rmag_nxt, s2_omag_r, s2_omag_nxt;

  // Stage 3: quotient magnitudes.
  logic              s3_v_r;
  logic [ADDR_W-1:0] s3_wp_r;
  logic              s3_rneg_r, s3_oneg_r;
  logic [QUO_W-1:0]  s3_rq_r, s3_rq_nxt, s3_oq_r, s3_oq_nxt;

  // Result register.
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_nz_r;

  logic [PCT_W-1:0]           wet_eff, fb_eff, dry_share;
  logic signed [SAMPLE_W-1:0] fx;
  logic signed [SUM_W-1:0]    ring_sum, out_sum, ring_abs, out_abs;
  logic [MULQ_W-1:0]          ring_mulq, out_mulq;
  logic signed [SAMPLE_W-1:0] ring_sat, out_sat;

  // Saturate a sign and quotient magnitude to a 16-bit sample.
  function automatic logic signed [SAMPLE_W-1:0] sat_apply(input logic neg,
                                                          input logic [QUO_W-1:0] q);
    logic [QUO_W-1:0]           nq;
    logic signed [SAMPLE_W-1:0] r;
    nq = -q;
    if (!neg) begin
      r = (q > QUO_W'(SAT_MAX)) ? SAMPLE_W'(SAT_MAX) : $signed(q[SAMPLE_W-1:0]);
    end else begin
      r = (q > QUO_W'(SAT_MAG_MIN)) ? SAMPLE_W'(SAT_MIN) : $signed(nq[SAMPLE_W-1:0]);
    end
    return r;
  endfunction

  // The whole pipeline moves when the result register is free or being taken.
  assign advance = !out_valid_r || out_ch.ready;

  // Hold a request whose delayed entry is still being computed further down.
  assign hazard = !pop_item.fx_zero &&
                  ((s0_v_r && (s0_wp_r == pop_item.rp)) ||
                   (s1_v_r && (s1_wp_r == pop_item.rp)) ||
                   (s2_v_r && (s2_wp_r == pop_item.rp)) ||
                   (s3_v_r && (s3_wp_r == pop_item.rp)));
  assign pop_ready = advance && !hazard;
  assign pop       = pop_valid && pop_ready;

  // Echo ring storage.
  fed_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (advance && s3_v_r),
    .waddr (s3_wp_r),
    .wdata (ring_sat),
    .re    (advance),
    .raddr (pop_item.rp),
    .rdata (ram_rdata)
  );

  // Clamp the mix percentages.
  always_comb begin
    wet_eff   = (cfg.wet > PCT_W'(WET_MAX)) ? PCT_W'(WET_MAX) : cfg.wet;
    fb_eff    = (cfg.fb > PCT_W'(FB_MAX)) ? PCT_W'(FB_MAX) : cfg.fb;
    dry_share = PCT_W'(PCT_FULL) - wet_eff;
  end

  // Stage 1 products of the delayed and dry samples.
  always_comb begin
    fx          = s0_zero_r ? '0 : $signed(ram_rdata);
    s1_fb_nxt   = PROD_W'(fx) * PROD_W'($signed({1'b0, fb_eff}));
    s1_wet_nxt  = PROD_W'(fx) * PROD_W'($signed({1'b0, wet_eff}));
    s1_d100_nxt = PROD_W'(s0_dry_r) * PROD_W'(PCT_FULL);
    s1_dmix_nxt = PROD_W'(s0_dry_r) * PROD_W'($signed({1'b0, dry_share}));
  end

  // Stage 2 sums split into sign and magnitude.
  always_comb begin
    ring_sum    = SUM_W'(s1_fb_r) + SUM_W'(s1_d100_r);
    out_sum     = SUM_W'(s1_wet_r) + SUM_W'(s1_dmix_r);
    s2_rneg_nxt = ring_sum[SUM_W-1];
    s2_oneg_nxt = out_sum[SUM_W-1];
    ring_abs    = s2_rneg_nxt ? -ring_sum : ring_sum;
    out_abs     = s2_oneg_nxt ? -out_sum : out_sum;
    s2_rmag_nxt = ring_abs[MAG_W-1:0];
    s2_omag_nxt = out_abs[MAG_W-1:0];
  end

  // Stage 3 truncating division of the magnitudes by 100.
  always_comb begin
    ring_mulq = MULQ_W'(s2_rmag_r) * MULQ_W'(RECIP);
    out_mulq  = MULQ_W'(s2_omag_r) * MULQ_W'(RECIP);
    s3_rq_nxt = ring_mulq[DIV_SHIFT +: QUO_W];
    s3_oq_nxt = out_mulq[DIV_SHIFT +: QUO_W];
  end

  // Final signed, saturated values for the ring and the result.
  always_comb begin
    ring_sat = sat_apply(s3_rneg_r, s3_rq_r);
    out_sat  = sat_apply(s3_oneg_r, s3_oq_r);
  end

  // Stage valid bits and the result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s0_v_r      <= pop;
      s1_v_r      <= s0_v_r;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (advance) begin
      s0_wp_r      <= pop_item.wp;
      s0_dry_r     <= pop_item.dry;
      s0_zero_r    <= pop_item.fx_zero;
      s1_wp_r      <= s0_wp_r;
      s1_fb_r      <= s1_fb_nxt;
      s1_d100_r    <= s1_d100_nxt;
      s1_wet_r     <= s1_wet_nxt;
      s1_dmix_r    <= s1_dmix_nxt;
      s2_wp_r      <= s1_wp_r;
      s2_rneg_r    <= s2_rneg_nxt;
      s2_oneg_r    <= s2_oneg_nxt;
      s2_rmag_r    <= s2_rmag_nxt;
      s2_omag_r    <= s2_omag_nxt;
      s3_wp_r      <= s2_wp_r;
      s3_rneg_r    <= s2_rneg_r;
      s3_oneg_r    <= s2_oneg_r;
      s3_rq_r      <= s3_rq_nxt;
      s3_oq_r      <= s3_oq_nxt;
      out_sample_r <= out_sat;
      out_nz_r     <= (out_sat != '0);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sample_out  = out_sample_r;
  assign out_ch.nonzero_out = out_nz_r;

`ifndef SYNTHESIS
  // A ring read never overlaps the write-back of the same entry.
  a_no_stale_read: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !pop_item.fx_zero && s3_v_r) |-> (s3_wp_r != pop_item.rp))
    else $error("ring read collides with pending write-back");

  // A stalled pipeline keeps its contents.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(s3_v_r) && $stable(out_valid_r) && $stable(out_sample_r)))
    else $error("pipeline moved while stalled");

  // A new result only comes from a request that left the last stage.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s3_v_r))
    else $error("result appeared without a request");
`endif

endmodule

// File: hw/rtl/feedback_echo_delay_core.sv
// Top level of the feedback echo delay: configuration registers, front, queue and back.
//
// Usage:
//   in_ch carries one signed 16-bit sample per request with a silent flag (dry term
//   zero) and a flush_first flag (ring cleared before the sample). out_ch returns one
//   mixed, saturated sample per request, in order, with a nonzero flag.
//   Registers (APB, byte address 4*index): wet_percent, feedback_percent,
//   delay_samples; write them only while no request is in flight.
// Path: queue, ring read, products, sums, quotients, result register.
// Throughput: one request per cycle while delay_samples is 5 or more and out_ch.ready
//   stays high. A shorter delay reads an entry still inside the 4-stage arithmetic
//   pipeline, so the back holds that request until the write-back. The single ring
//   read port and write port set the peak rate.
// Reset: registers return to 50, 50 and 22050; the write position goes to zero and
//   the ring fill count to zero, so the ring reads as all zero at once, with no
//   clearing pass. A flush zeroes only the fill count, in the same cycle.
// Stall: the result register holds until taken; a 4-entry queue keeps accepting
//   requests, and in_ch.ready falls only when that queue is full.
module feedback_echo_delay_core import fed_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  fed_in_if.sink             in_ch,
  fed_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [PCT_W-1:0] wet_r, wet_nxt;
  logic [PCT_W-1:0] fb_r, fb_nxt;
  logic [DLY_W-1:0] dly_r, dly_nxt;
  logic             wr_en;
  fed_reg_t         reg_idx;
  fed_cfg_t         cfg;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  fed_item_t        push_item, pop_item;

  // Register writes complete in the access phase; the port never waits.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = fed_reg_t'(paddr[PADDR_W-1:2]);

  always_comb begin
    wet_nxt = wet_r;
    fb_nxt  = fb_r;
    dly_nxt = dly_r;
    if (wr_en) begin
      case (reg_idx)
        REG_WET: wet_nxt = pwdata[PCT_W-1:0];
        REG_FB:  fb_nxt  = pwdata[PCT_W-1:0];
        REG_DLY: dly_nxt = pwdata[DLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wet_r <= PCT_W'(RST_WET);
      fb_r  <= PCT_W'(RST_FB);
      dly_r <= DLY_W'(RST_DLY);
    end else begin
      wet_r <= wet_nxt;
      fb_r  <= fb_nxt;
      dly_r <= dly_nxt;
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_WET: prdata = PDATA_W'(wet_r);
      REG_FB:  prdata = PDATA_W'(fb_r);
      REG_DLY: prdata = PDATA_W'(dly_r);
      default: prdata = '0;
    endcase
  end

  assign cfg.wet = wet_r;
  assign cfg.fb  = fb_r;

  fed_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .dly        (dly_r),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  fed_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  fed_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .cfg       (cfg),
    .out_ch    (out_ch)
  );

endmodule
